// ===== rtl/cde_pkg.sv =====
// ----------------------------------------------------------------------------
// cde_pkg
// Shared types, codes and calendar tables for the calendar date engine.
// ----------------------------------------------------------------------------
package cde_pkg;

	localparam int DEF_MAX_YEAR = 9999;
	localparam int MAX_DAY_STEP = 65535;

	localparam int YEAR_W     = 14;
	localparam int DIST_W     = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam int RESET_DAY   = 1;
	localparam int RESET_MONTH = 1;
	localparam int RESET_YEAR  = 2000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_DAY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MONTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_YEAR  = 2'd2;

	localparam logic [1:0] CMD_RESTART   = 2'd0;
	localparam logic [1:0] CMD_ADD_DAYS  = 2'd1;
	localparam logic [1:0] CMD_ADD_MONTH = 2'd2;
	localparam logic [1:0] CMD_MEASURE   = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INVALID  = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	localparam logic [1:0] ORD_EQUAL  = 2'd0;
	localparam logic [1:0] ORD_BEFORE = 2'd1;
	localparam logic [1:0] ORD_AFTER  = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [15:0]       day_count;
		logic [4:0]        anchor_day;
		logic [4:0]        other_day;
		logic [3:0]        other_month;
		logic [YEAR_W-1:0] other_year;
	} cde_in_t;

	typedef struct packed {
		logic [4:0]        now_day;
		logic [3:0]        now_month;
		logic [YEAR_W-1:0] now_year;
		logic              leap_year;
		logic [8:0]        days_into_year;
		logic [8:0]        days_to_year_end;
		logic [4:0]        days_to_month_end;
		logic [1:0]        order;
		logic [DIST_W-1:0] day_distance;
		logic [1:0]        status;
	} cde_out_t;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// zero for a month outside 1..12
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		len = 5'd0;
		if (m >= 4'd1 && m <= 4'd12) begin
			len = MONTH_LEN[m - 4'd1];
		end
		if (m == 4'd2 && leap) begin
			len = 5'd29;
		end
		return len;
	endfunction

	// days in the months before m
	function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
		logic [8:0] n;
		unique case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		if (leap && m > 4'd2) begin
			n = n + 9'd1;
		end
		return n;
	endfunction

	function automatic logic [8:0] ordinal(input logic [4:0] d, input logic [3:0] m,
			input logic leap);
		return 9'(d) + cum_days(m, leap);
	endfunction

	function automatic logic [8:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	// y = 100*q + 4*r + ylo with q, r from y/4 divided by 25
	function automatic logic leap_from_div(input logic [1:0] ylo, input logic [4:0] r,
			input logic [1:0] qlo);
		return (ylo == 2'd0) && ((r != 5'd0) || (qlo == 2'd0));
	endfunction

endpackage

// ===== rtl/calendar_date_engine.sv =====
// ----------------------------------------------------------------------------
// calendar_date_engine
// Keeps one Gregorian date and runs one command per input transaction:
// restart from the start registers, add days, add one month, or measure the
// day distance to another date. One result transaction per command. Commands
// run one at a time; in_ready is high only between commands, and a finished
// result waits in the output register while the next command is taken.
// Restart divides the start year, checks it and finishes. Add month steps the
// month and clamps the day, or finishes at once when it saturates. Measure
// divides, checks the other date (finishing at once if it is invalid), forms
// both day numbers and compares. Add days crosses year boundaries singly
// (about 180 for 65535 days), then walks up to 11 months of the final year.
// A result still waiting in the output register holds the finish step until
// it is taken. All year division goes through one shared
// divide-by-25 multiplier; leap state of the current date is kept in
// year-mod-100 and century-mod-4 counters so day and month stepping needs no
// division. Overflow past 31.12 of MAX_YEAR saturates there with status 2.
// ----------------------------------------------------------------------------
module calendar_date_engine #(
	parameter int MAX_YEAR = cde_pkg::DEF_MAX_YEAR
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cde_pkg::cde_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cde_pkg::cde_out_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cde_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cde_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import cde_pkg::*;

	localparam int YW  = ($clog2(MAX_YEAR + 1) > YEAR_W) ? $clog2(MAX_YEAR + 1) : YEAR_W;
	localparam int XW  = YW - 2;
	localparam int QW  = XW - 4;
	localparam int DNW = YW + 10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RS_DIV,
		ST_RS_CHK,
		ST_AD_YEAR,
		ST_AD_MONTH,
		ST_AM_STEP,
		ST_AM_CLAMP,
		ST_MS_DIV,
		ST_MS_CHK,
		ST_MS_DNA,
		ST_MS_DNB,
		ST_MS_CMP,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [4:0]        start_day_q;
	logic [3:0]        start_month_q;
	logic [YEAR_W-1:0] start_year_q;

	logic [4:0]    cur_day_q;
	logic [3:0]    cur_month_q;
	logic [YW-1:0] cur_year_q;
	logic [6:0]    cur_c100_q;
	logic [1:0]    cur_c4_q;

	logic [1:0]     status_q;
	logic [1:0]     order_q;
	logic [DNW-1:0] dist_q;
	cde_out_t       out_q;
	logic           out_valid_q;

	cde_in_t        in_q;
	logic [15:0]    n_q;
	logic [8:0]     t_q;
	logic [3:0]     m_q;
	logic           leap_o_q;
	logic [DNW-1:0] p365_q;
	logic [DNW-1:0] dn_a_q;
	logic [DNW-1:0] dn_b_q;

	logic          div_en;
	logic [XW-1:0] div_x;
	logic [QW-1:0] div_quo;
	logic [4:0]    div_rem;
	logic [XW-1:0] div_opnd;

	logic           leap_cur;
	logic [8:0]     ord_cur;
	logic [8:0]     left_cur;
	logic [4:0]     mlen_cur;
	logic [YW-1:0]  year_inc;
	logic [6:0]     c100_inc;
	logic [1:0]     c4_inc;
	logic           year_at_max;
	logic [YW-1:0]  start_year_ext;
	logic [YW-1:0]  oth_year_ext;
	logic [YW-1:0]  cur_pm1;
	logic [YW-1:0]  oth_pm1;
	logic           leap_start;
	logic           leap_oth;
	logic           start_ok;
	logic           oth_ok;
	logic [8:0]     ord_oth;
	logic [DNW-1:0] dn_base;
	logic [4:0]     walk_len;
	logic [4:0]     anchor;
	logic [4:0]     am_day;

	cde_div25 #(
		.XW(XW)
	) u_div25 (
		.clk  (clk),
		.en   (div_en),
		.x    (div_x),
		.quo  (div_quo),
		.rem  (div_rem),
		.opnd (div_opnd)
	);

	// current date helpers
	assign leap_cur    = (cur_year_q[1:0] == 2'd0) && ((cur_c100_q != 7'd0) || (cur_c4_q == 2'd0));
	assign ord_cur     = ordinal(cur_day_q, cur_month_q, leap_cur);
	assign left_cur    = year_len(leap_cur) - ord_cur;
	assign mlen_cur    = month_len(cur_month_q, leap_cur);
	assign year_inc    = cur_year_q + YW'(1);
	assign c100_inc    = (cur_c100_q == 7'd99) ? 7'd0 : cur_c100_q + 7'd1;
	assign c4_inc      = (cur_c100_q == 7'd99) ? cur_c4_q + 2'd1 : cur_c4_q;
	assign year_at_max = cur_year_q >= YW'(MAX_YEAR);

	assign start_year_ext = YW'(start_year_q);
	assign oth_year_ext   = YW'(in_q.other_year);
	assign cur_pm1        = cur_year_q - YW'(1);
	assign oth_pm1        = oth_year_ext - YW'(1);

	assign leap_start = leap_from_div(start_year_q[1:0], div_rem, div_quo[1:0]);
	assign leap_oth   = leap_from_div(in_q.other_year[1:0], div_rem, div_quo[1:0]);

	assign start_ok = (start_month_q >= 4'd1) && (start_month_q <= 4'd12)
		&& (start_year_ext >= YW'(1)) && (start_year_ext <= YW'(MAX_YEAR))
		&& (start_day_q >= 5'd1) && (start_day_q <= month_len(start_month_q, leap_start));
	assign oth_ok = (in_q.other_month >= 4'd1) && (in_q.other_month <= 4'd12)
		&& (oth_year_ext >= YW'(1)) && (oth_year_ext <= YW'(MAX_YEAR))
		&& (in_q.other_day >= 5'd1)
		&& (in_q.other_day <= month_len(in_q.other_month, leap_oth));

	assign ord_oth = ordinal(in_q.other_day, in_q.other_month, leap_o_q);
	// (y-1)*365 + (y-1)/4 - (y-1)/100 + (y-1)/400
	assign dn_base = p365_q + DNW'(div_opnd) - DNW'(div_quo) + DNW'(div_quo[QW-1:2]);

	assign walk_len = month_len(m_q, leap_cur);
	assign anchor   = (in_q.anchor_day == 5'd0) ? 5'd1 : in_q.anchor_day;
	assign am_day   = (anchor > mlen_cur) ? mlen_cur : anchor;

	always_comb begin
		div_en = 1'b0;
		div_x  = '0;
		case (state_q)
			ST_RS_DIV: begin
				div_en = 1'b1;
				div_x  = start_year_ext[YW-1:2];
			end
			ST_MS_DIV: begin
				div_en = 1'b1;
				div_x  = oth_year_ext[YW-1:2];
			end
			ST_MS_CHK: begin
				div_en = 1'b1;
				div_x  = cur_pm1[YW-1:2];
			end
			ST_MS_DNA: begin
				div_en = 1'b1;
				div_x  = oth_pm1[YW-1:2];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_day_q   <= 5'(RESET_DAY);
			start_month_q <= 4'(RESET_MONTH);
			start_year_q  <= YEAR_W'(RESET_YEAR);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_DAY:   start_day_q   <= cfg_data[4:0];
				REG_START_MONTH: start_month_q <= cfg_data[3:0];
				REG_START_YEAR:  start_year_q  <= cfg_data[YEAR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_day_q   <= 5'(RESET_DAY);
			cur_month_q <= 4'(RESET_MONTH);
			cur_year_q  <= YW'(RESET_YEAR);
			cur_c100_q  <= 7'(RESET_YEAR % 100);
			cur_c4_q    <= 2'((RESET_YEAR / 100) % 4);
			status_q    <= STAT_OK;
			order_q     <= ORD_EQUAL;
			dist_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the finish step reloads the output register itself
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						status_q <= STAT_OK;
						order_q  <= ORD_EQUAL;
						dist_q   <= '0;
						unique case (in_data.command)
							CMD_RESTART:   state_q <= ST_RS_DIV;
							CMD_ADD_DAYS:  state_q <= ST_AD_YEAR;
							CMD_ADD_MONTH: state_q <= ST_AM_STEP;
							CMD_MEASURE:   state_q <= ST_MS_DIV;
						endcase
					end
				end
				ST_RS_DIV: begin
					state_q <= ST_RS_CHK;
				end
				ST_RS_CHK: begin
					if (start_ok) begin
						cur_day_q   <= start_day_q;
						cur_month_q <= start_month_q;
						cur_year_q  <= start_year_ext;
						cur_c100_q  <= {div_rem, start_year_q[1:0]};
						cur_c4_q    <= div_quo[1:0];
					end else begin
						status_q <= STAT_INVALID;
					end
					state_q <= ST_FINISH;
				end
				ST_AD_YEAR: begin
					if (n_q <= 16'(left_cur)) begin
						state_q <= ST_AD_MONTH;
					end else if (year_at_max) begin
						cur_day_q   <= 5'd31;
						cur_month_q <= 4'd12;
						status_q    <= STAT_OVERFLOW;
						state_q     <= ST_FINISH;
					end else begin
						cur_year_q  <= year_inc;
						cur_c100_q  <= c100_inc;
						cur_c4_q    <= c4_inc;
						cur_month_q <= 4'd1;
						cur_day_q   <= 5'd1;
					end
				end
				ST_AD_MONTH: begin
					if (!(m_q < 4'd12 && t_q > 9'(walk_len))) begin
						cur_month_q <= m_q;
						cur_day_q   <= t_q[4:0];
						state_q     <= ST_FINISH;
					end
				end
				ST_AM_STEP: begin
					if (cur_month_q >= 4'd12) begin
						if (year_at_max) begin
							cur_day_q   <= 5'd31;
							cur_month_q <= 4'd12;
							status_q    <= STAT_OVERFLOW;
							state_q     <= ST_FINISH;
						end else begin
							cur_month_q <= 4'd1;
							cur_year_q  <= year_inc;
							cur_c100_q  <= c100_inc;
							cur_c4_q    <= c4_inc;
							state_q     <= ST_AM_CLAMP;
						end
					end else begin
						cur_month_q <= cur_month_q + 4'd1;
						state_q     <= ST_AM_CLAMP;
					end
				end
				ST_AM_CLAMP: begin
					cur_day_q <= am_day;
					state_q   <= ST_FINISH;
				end
				ST_MS_DIV: begin
					state_q <= ST_MS_CHK;
				end
				ST_MS_CHK: begin
					if (oth_ok) begin
						state_q <= ST_MS_DNA;
					end else begin
						status_q <= STAT_INVALID;
						state_q  <= ST_FINISH;
					end
				end
				ST_MS_DNA: begin
					state_q <= ST_MS_DNB;
				end
				ST_MS_DNB: begin
					state_q <= ST_MS_CMP;
				end
				ST_MS_CMP: begin
					if (dn_a_q < dn_b_q) begin
						order_q <= ORD_BEFORE;
						dist_q  <= dn_b_q - dn_a_q;
					end else if (dn_a_q > dn_b_q) begin
						order_q <= ORD_AFTER;
						dist_q  <= dn_a_q - dn_b_q;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_q.now_day           <= cur_day_q;
						out_q.now_month         <= cur_month_q;
						out_q.now_year          <= cur_year_q[YEAR_W-1:0];
						out_q.leap_year         <= leap_cur;
						out_q.days_into_year    <= ord_cur;
						out_q.days_to_year_end  <= left_cur;
						out_q.days_to_month_end <= mlen_cur - cur_day_q;
						out_q.order             <= order_q;
						out_q.day_distance      <= dist_q[DIST_W-1:0];
						out_q.status            <= status_q;
						out_valid_q             <= 1'b1;
						state_q                 <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					in_q <= in_data;
					if (32'(in_data.day_count) > MAX_DAY_STEP) begin
						n_q <= 16'(MAX_DAY_STEP);
					end else begin
						n_q <= in_data.day_count;
					end
				end
			end
			ST_AD_YEAR: begin
				if (n_q <= 16'(left_cur)) begin
					t_q <= ord_cur + 9'(n_q);
					m_q <= 4'd1;
				end else begin
					n_q <= n_q - (16'(left_cur) + 16'd1);
				end
			end
			ST_AD_MONTH: begin
				if (m_q < 4'd12 && t_q > 9'(walk_len)) begin
					t_q <= t_q - 9'(walk_len);
					m_q <= m_q + 4'd1;
				end
			end
			ST_MS_CHK: begin
				leap_o_q <= leap_oth;
				p365_q   <= DNW'(cur_pm1) * DNW'(365);
			end
			ST_MS_DNA: begin
				dn_a_q <= dn_base + DNW'(ord_cur);
				p365_q <= DNW'(oth_pm1) * DNW'(365);
			end
			ST_MS_DNB: begin
				dn_b_q <= dn_base + DNW'(ord_oth);
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("engine took a second transaction while busy");

	a_idle_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cur_month_q >= 4'd1 && cur_month_q <= 4'd12
			&& cur_day_q >= 5'd1 && cur_day_q <= mlen_cur))
		else $error("current date invalid between commands");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_year_q >= YW'(1) && cur_year_q <= YW'(MAX_YEAR))
		else $error("current year out of range");

	a_century_count: assert property (@(posedge clk) disable iff (!arst_n)
		cur_c100_q < 7'd100)
		else $error("year mod 100 counter out of range");

	a_equal_no_distance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.order == ORD_EQUAL) |-> (out_q.day_distance == '0))
		else $error("distance reported for equal dates");

endmodule

// ===== rtl/cde_div25.sv =====
// ----------------------------------------------------------------------------
// cde_div25
// Shared divide-by-25 unit: reciprocal multiply, registered quotient,
// remainder recovered by shift-add from the registered values.
// ----------------------------------------------------------------------------
module cde_div25 #(
	parameter int XW = 14
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XW-1:0] x,
	output logic [XW-5:0] quo,
	output logic [4:0]    rem,
	output logic [XW-1:0] opnd
);

	localparam int K  = XW + 5;
	localparam int QW = XW - 4;
	localparam int RW = XW + 1;
	localparam int PW = 2 * XW + 1;
	// quotient error stays below 1/32 for any x below 2**XW
	localparam logic [RW-1:0] RECIP = RW'(((64'd1 << K) + 64'd24) / 64'd25);

	logic [PW-1:0] prod;
	logic [QW-1:0] quo_q;
	logic [XW-1:0] opnd_q;
	logic [XW-1:0] mul25;
	logic [XW-1:0] diff;

	assign prod = PW'(x) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q  <= prod[PW-1:K];
			opnd_q <= x;
		end
	end

	assign mul25 = (XW'(quo_q) << 4) + (XW'(quo_q) << 3) + XW'(quo_q);
	assign diff  = opnd_q - mul25;
	assign quo   = quo_q;
	assign rem   = diff[4:0];
	assign opnd  = opnd_q;

endmodule

// ===== dv/cde_checker.sv =====
// ----------------------------------------------------------------------------
// cde_checker
// Watches the command, result and register channels of the calendar date
// engine, keeps its own copy of the date and start registers, predicts one
// result per accepted command and compares each returned result field by
// field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cde_checker #(
	parameter int MAX_YEAR = cde_pkg::DEF_MAX_YEAR
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  cde_pkg::cde_in_t               in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  cde_pkg::cde_out_t              out_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [cde_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cde_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             outstanding,
	output int                             fail_count
);
	import cde_pkg::*;

	int unsigned load_day   = RESET_DAY;
	int unsigned load_month = RESET_MONTH;
	int unsigned load_year  = RESET_YEAR;
	int unsigned date_day   = RESET_DAY;
	int unsigned date_month = RESET_MONTH;
	int unsigned date_year  = RESET_YEAR;

	cde_out_t expected_dates [$];
	int mismatches = 0;

	initial outstanding = 0;
	assign fail_count = mismatches;

	function automatic bit leap_of(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		case (m)
			2:                   return leap_of(y) ? 29 : 28;
			4, 6, 9, 11:         return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default:             return 0;
		endcase
	endfunction

	function automatic int unsigned year_days(input int unsigned y);
		return leap_of(y) ? 366 : 365;
	endfunction

	function automatic bit date_ok(input int unsigned d, input int unsigned m,
			input int unsigned y);
		if (m < 1 || m > 12 || y < 1 || y > MAX_YEAR) begin
			return 1'b0;
		end
		return d >= 1 && d <= month_days(m, y);
	endfunction

	function automatic int unsigned day_of_year(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned n;
		n = d;
		for (int unsigned i = 1; i < m && i <= 12; i++) begin
			n += month_days(i, y);
		end
		return n;
	endfunction

	// days since a fixed epoch, so two dates subtract directly
	function automatic longint unsigned abs_day(input int unsigned d, input int unsigned m,
			input int unsigned y);
		longint unsigned p;
		p = longint'(y) - 1;
		return p * 365 + p / 4 - p / 100 + p / 400 + day_of_year(d, m, y);
	endfunction

	function automatic void pin_to_last_day();
		date_day = 31;
		date_month = 12;
		date_year = MAX_YEAR;
	endfunction

	// whole years first, then months of the final year
	function automatic logic [1:0] advance_days(input int unsigned count);
		int unsigned n, pos, left, t, m;
		n = count;
		while (n > 0) begin
			pos = day_of_year(date_day, date_month, date_year);
			left = year_days(date_year) - pos;
			if (n <= left) begin
				t = pos + n;
				m = 1;
				while (m < 12 && t > month_days(m, date_year)) begin
					t -= month_days(m, date_year);
					m++;
				end
				date_month = m;
				date_day = t;
				return STAT_OK;
			end
			n -= left + 1;
			if (date_year >= MAX_YEAR) begin
				pin_to_last_day();
				return STAT_OVERFLOW;
			end
			date_year++;
			date_month = 1;
			date_day = 1;
		end
		return STAT_OK;
	endfunction

	function automatic logic [1:0] next_month(input int unsigned anchor);
		int unsigned want, len;
		if (date_month >= 12) begin
			if (date_year >= MAX_YEAR) begin
				pin_to_last_day();
				return STAT_OVERFLOW;
			end
			date_month = 1;
			date_year++;
		end else begin
			date_month++;
		end
		len = month_days(date_month, date_year);
		want = (anchor < 1) ? 1 : anchor;
		date_day = (want > len) ? len : want;
		return STAT_OK;
	endfunction

	function automatic cde_out_t run_command(input cde_in_t c);
		cde_out_t r;
		logic [1:0] st, rel;
		longint unsigned here, there, gap;
		int unsigned count, pos;
		st = STAT_OK;
		rel = ORD_EQUAL;
		gap = 0;
		case (c.command)
			CMD_RESTART: begin
				if (date_ok(load_day, load_month, load_year)) begin
					date_day = load_day;
					date_month = load_month;
					date_year = load_year;
				end else begin
					st = STAT_INVALID;
				end
			end
			CMD_ADD_DAYS: begin
				count = c.day_count;
				if (count > MAX_DAY_STEP) begin
					count = MAX_DAY_STEP;
				end
				st = advance_days(count);
			end
			CMD_ADD_MONTH: begin
				st = next_month(c.anchor_day);
			end
			default: begin
				if (date_ok(c.other_day, c.other_month, c.other_year)) begin
					here = abs_day(date_day, date_month, date_year);
					there = abs_day(c.other_day, c.other_month, c.other_year);
					if (here < there) begin
						rel = ORD_BEFORE;
						gap = there - here;
					end else if (here > there) begin
						rel = ORD_AFTER;
						gap = here - there;
					end
				end else begin
					st = STAT_INVALID;
				end
			end
		endcase
		pos = day_of_year(date_day, date_month, date_year);
		r.now_day           = 5'(date_day);
		r.now_month         = 4'(date_month);
		r.now_year          = YEAR_W'(date_year);
		r.leap_year         = leap_of(date_year);
		r.days_into_year    = 9'(pos);
		r.days_to_year_end  = 9'(year_days(date_year) - pos);
		r.days_to_month_end = 5'(month_days(date_month, date_year) - date_day);
		r.order             = rel;
		r.day_distance      = DIST_W'(gap);
		r.status            = st;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cde_out_t want;
		if (!arst_n) begin
			load_day = RESET_DAY;
			load_month = RESET_MONTH;
			load_year = RESET_YEAR;
			date_day = RESET_DAY;
			date_month = RESET_MONTH;
			date_year = RESET_YEAR;
			expected_dates.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_START_DAY:   load_day = cfg_data[4:0];
					REG_START_MONTH: load_month = cfg_data[3:0];
					REG_START_YEAR:  load_year = cfg_data[YEAR_W-1:0];
					default:         ;
				endcase
			end
			if (in_valid && in_ready) begin
				expected_dates.push_back(run_command(in_data));
			end
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					mismatches++;
					$display("%0t: result transaction with no command pending, got %p",
						$time, out_data);
				end else begin
					want = expected_dates.pop_front();
					check_field("now_day", want.now_day, out_data.now_day);
					check_field("now_month", want.now_month, out_data.now_month);
					check_field("now_year", want.now_year, out_data.now_year);
					check_field("leap_year", want.leap_year, out_data.leap_year);
					check_field("days_into_year", want.days_into_year,
						out_data.days_into_year);
					check_field("days_to_year_end", want.days_to_year_end,
						out_data.days_to_year_end);
					check_field("days_to_month_end", want.days_to_month_end,
						out_data.days_to_month_end);
					check_field("order", want.order, out_data.order);
					check_field("day_distance", want.day_distance, out_data.day_distance);
					check_field("status", want.status, out_data.status);
				end
			end
			outstanding <= expected_dates.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the calendar date engine: a directed pass over
// field extremes, leap days, invalid dates and year overflow, then random
// commands under several start dates and idling patterns. Checking is done
// by cde_checker instantiated beside the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import cde_pkg::*;

	localparam int LAST_YEAR    = DEF_MAX_YEAR;
	localparam int HOLD_CYCLES  = 400;
	localparam int CHUNK_ITEMS  = 34;
	localparam int DRAIN_CYCLES = 200;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	cde_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	cde_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int outstanding;
	int fail_count;
	int send_idle_pct = 23;
	int recv_idle_pct = 79;
	bit hold_req = 1'b0;

	calendar_date_engine #(
		.MAX_YEAR(LAST_YEAR)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cde_checker #(
		.MAX_YEAR(LAST_YEAR)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("** calendar_date_engine: FAILED **");
		$finish;
	end

	// result side: random back-pressure, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function automatic cde_in_t cmd_item(input logic [1:0] cmd, input int count,
			input int anchor, input int od, input int om, input int oy);
		cde_in_t it;
		it.command = cmd;
		it.day_count = 16'(count);
		it.anchor_day = 5'(anchor);
		it.other_day = 5'(od);
		it.other_month = 4'(om);
		it.other_year = YEAR_W'(oy);
		return it;
	endfunction

	function automatic cde_in_t random_item();
		cde_in_t it;
		int pick;
		it.anchor_day = 5'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			it.day_count = 16'($urandom_range(0, 40));
		end else if (pick < 80) begin
			it.day_count = 16'($urandom_range(0, 1000));
		end else if (pick < 96) begin
			it.day_count = 16'($urandom);
		end else begin
			it.day_count = 16'hffff;
		end
		if ($urandom_range(0, 99) < 80) begin
			it.other_year = YEAR_W'($urandom_range(1, LAST_YEAR));
			it.other_month = 4'($urandom_range(1, 12));
			it.other_day = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31))
				: 5'($urandom_range(1, 28));
		end else begin
			it.other_year = YEAR_W'($urandom);
			it.other_month = 4'($urandom);
			it.other_day = 5'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			it.command = CMD_RESTART;
		end else if (pick < 45) begin
			it.command = CMD_ADD_DAYS;
		end else if (pick < 70) begin
			it.command = CMD_ADD_MONTH;
		end else begin
			it.command = CMD_MEASURE;
		end
		return it;
	endfunction

	// valid stays high across back-to-back transactions
	task automatic send_cmd(input cde_in_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_start(input int d, input int m, input int y);
		logic [CFG_DATA_W-1:0] word [3];
		logic [CFG_IDX_W-1:0]  reg_idx [3];
		bit junk;
		wait_drain();
		junk = $urandom_range(0, 1);
		reg_idx[0] = REG_START_DAY;
		reg_idx[1] = REG_START_MONTH;
		reg_idx[2] = REG_START_YEAR;
		// upper data bits beyond the field width are don't-care
		word[0] = {junk ? 9'($urandom) : 9'd0, 5'(d)};
		word[1] = {junk ? 10'($urandom) : 10'd0, 4'(m)};
		word[2] = 14'(y);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx[i];
			cfg_data <= word[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_start(output int d, output int m, output int y);
		case ($urandom_range(0, 5))
			0: begin
				d = 1; m = 1; y = 1;
			end
			1: begin
				d = 31; m = 12; y = LAST_YEAR;
			end
			2: begin
				d = $urandom_range(1, 28); m = $urandom_range(1, 12);
				y = $urandom_range(1, LAST_YEAR);
			end
			3: begin
				d = $urandom_range(1, 31); m = $urandom_range(1, 12);
				y = $urandom_range(LAST_YEAR - 9, LAST_YEAR);
			end
			4: begin
				d = $urandom_range(0, 31); m = $urandom_range(0, 15);
				y = $urandom_range(0, 16383);
			end
			default: begin
				d = RESET_DAY; m = RESET_MONTH; y = RESET_YEAR;
			end
		endcase
	endtask

	initial begin
		int d, m, y;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// date after reset is 1.1.2000
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 1, 1, 2000));
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 1, 1, 1));
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 31, 12, LAST_YEAR));
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 29, 2, 1900));
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 29, 2, 2000));
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 31, 15, 16383));
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 1, 1, LAST_YEAR + 1));
		send_cmd(cmd_item(CMD_ADD_DAYS, 0, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_DAYS, 59, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_DAYS, 1, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_MONTH, 0, 31, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_MONTH, 0, 0, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_DAYS, 65535, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_RESTART, 0, 1, 0, 0, 0));

		// last representable day, then steps past it
		set_start(31, 12, LAST_YEAR);
		send_cmd(cmd_item(CMD_RESTART, 0, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_DAYS, 1, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_MONTH, 0, 31, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_DAYS, 0, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_MEASURE, 0, 1, 1, 1, 1));

		// century year that is not a leap year
		set_start(29, 2, 2100);
		send_cmd(cmd_item(CMD_RESTART, 0, 1, 0, 0, 0));

		// anchor clamped to a leap february
		set_start(31, 1, 2004);
		send_cmd(cmd_item(CMD_RESTART, 0, 1, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_MONTH, 0, 31, 0, 0, 0));
		send_cmd(cmd_item(CMD_ADD_MONTH, 0, 31, 0, 0, 0));

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 23; recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79; recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0; recv_idle_pct = 0;
				end
			endcase
			for (int chunk = 0; chunk < 4; chunk++) begin
				pick_start(d, m, y);
				set_start(d, m, y);
				if (mode == 2 && chunk == 1) begin
					// result side stalls while commands keep coming
					hold_req = 1'b1;
					repeat (12) begin
						send_cmd(cmd_item(CMD_ADD_MONTH, 0, $urandom_range(0, 31), 0, 0, 0));
					end
				end
				repeat (CHUNK_ITEMS) send_cmd(random_item());
			end
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("** calendar_date_engine: PASSED **");
		end else begin
			$display("** calendar_date_engine: FAILED **");
		end
		$finish;
	end

endmodule
